[hdl/skc_pkg.sv]
package skc_pkg;

    // default fraction bits of the level format
    localparam int FRAC_BITS_DEF    = 8;

    localparam int LEVEL_W          = 16;
    localparam int THR_W            = 7;
    localparam int RATIO_W          = 7;
    localparam int KNEE_W           = 4;
    localparam int MAKEUP_W         = 5;
    localparam int REG_IDX_W        = 2;

    // divisor width: 2 * 127 * 15 fits in 12 bits
    localparam int DIV_W            = 12;
    // quotient bits resolved per divider stage
    localparam int DIGITS_PER_STAGE = 8;

    localparam logic signed [THR_W-1:0] THR_RST    = -7'sd22;
    localparam logic [RATIO_W-1:0]      RATIO_RST  = 7'd8;
    localparam logic [KNEE_W-1:0]       KNEE_RST   = 4'd3;
    localparam logic [MAKEUP_W-1:0]     MAKEUP_RST = 5'd5;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_THRESHOLD = 2'd0,
        REG_RATIO     = 2'd1,
        REG_KNEE      = 2'd2,
        REG_MAKEUP    = 2'd3
    } t_reg_idx;

    // curve segment chosen for a beat
    typedef enum logic [1:0] {
        MODE_PASS = 2'd0,
        MODE_COMP = 2'd1,
        MODE_KNEE = 2'd2
    } t_mode;

    typedef struct packed {
        logic signed [THR_W-1:0] threshold_db;
        logic [RATIO_W-1:0]      ratio_halves;
        logic [KNEE_W-1:0]       knee_db;
        logic [MAKEUP_W-1:0]     makeup_db;
    } t_cfg;

    // side data that rides along the divider
    typedef struct packed {
        t_mode                     mode;
        logic                      neg;
        logic signed [LEVEL_W-1:0] x;
    } t_side;

endpackage

[hdl/skc_front.sv]
module skc_front #(
    parameter int FRAC_BITS = skc_pkg::FRAC_BITS_DEF,
    parameter int QW        = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  skc_pkg::t_cfg                         i_cfg,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic signed [skc_pkg::LEVEL_W-1:0]    i_level_in,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic [QW-1:0]                         o_acc,
    output logic [skc_pkg::DIV_W-1:0]             o_div,
    output skc_pkg::t_side                        o_side
);
    import skc_pkg::*;

    localparam int LW  = FRAC_BITS + 18;    // signed level difference
    localparam int DW  = FRAC_BITS + 19;    // compressed dividend
    localparam int DKW = FRAC_BITS + 4;     // knee offset, 0..knee*2^F
    localparam int SQW = 2 * DKW;
    localparam int PW  = SQW + 8;
    localparam int RKW = RATIO_W + KNEE_W;

    logic w_stall1, w_stall2, w_stall3;

    // stage 1: difference to threshold, segment select
    logic signed [LW-1:0] w_x, w_thr, w_diff, w_half;
    logic [DKW-1:0]       w_d;
    t_mode                w_mode;

    logic                      r_s1_valid;
    t_mode                     r_s1_mode;
    logic signed [LEVEL_W-1:0] r_s1_x;
    logic signed [LW-1:0]      r_s1_diff;
    logic [DKW-1:0]            r_s1_d;

    assign w_x    = LW'(i_level_in);
    assign w_thr  = LW'($signed(i_cfg.threshold_db)) <<< FRAC_BITS;
    assign w_half = $signed(LW'(i_cfg.knee_db)) <<< (FRAC_BITS - 1);
    assign w_diff = w_x - w_thr;
    assign w_d    = DKW'(w_diff + w_half);

    always_comb begin
        priority if (i_cfg.knee_db == '0) begin
            w_mode = (w_diff < 0) ? MODE_PASS : MODE_COMP;
        end else if (w_diff < -w_half) begin
            w_mode = MODE_PASS;
        end else if (w_diff > w_half) begin
            w_mode = MODE_COMP;
        end else begin
            w_mode = MODE_KNEE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!w_stall1) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_stall1) begin
            r_s1_mode <= w_mode;
            r_s1_x    <= i_level_in;
            r_s1_diff <= w_diff;
            r_s1_d    <= w_d;
        end
    end

    // stage 2: magnitude plus half divisor, knee offset squared
    logic [RATIO_W-1:0] w_rh;
    logic [LW-1:0]      w_abs;
    logic [DW-1:0]      w_mag;

    logic                      r_s2_valid;
    t_mode                     r_s2_mode;
    logic signed [LEVEL_W-1:0] r_s2_x;
    logic                      r_s2_neg;
    logic [DW-1:0]             r_s2_mag;
    logic [SQW-1:0]            r_s2_sq;

    // ratio below 1:1 behaves as 1:1
    assign w_rh  = (i_cfg.ratio_halves < RATIO_W'(2)) ? RATIO_W'(2) : i_cfg.ratio_halves;
    assign w_abs = r_s1_diff[LW-1] ? LW'(-r_s1_diff) : LW'(r_s1_diff);
    assign w_mag = {w_abs, 1'b0} + DW'(w_rh[RATIO_W-1:1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (!w_stall2) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_stall2) begin
            r_s2_mode <= r_s1_mode;
            r_s2_x    <= r_s1_x;
            r_s2_neg  <= r_s1_diff[LW-1];
            r_s2_mag  <= w_mag;
            r_s2_sq   <= SQW'(r_s1_d) * SQW'(r_s1_d);
        end
    end

    // stage 3: knee numerator scaled, dividend and divisor chosen
    logic [RKW-1:0] w_rk;
    logic [PW-1:0]  w_prod, w_num;

    logic                 r_s3_valid;
    logic [QW-1:0]        r_s3_acc;
    logic [DIV_W-1:0]     r_s3_div;
    t_side                r_s3_side;

    assign w_rk   = RKW'(w_rh) * RKW'(i_cfg.knee_db);
    assign w_prod = PW'(r_s2_sq) * PW'(w_rh - RATIO_W'(2));
    // adding half the divisor first gives round to nearest
    assign w_num  = w_prod + (PW'(w_rk) << FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (!w_stall3) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_stall3) begin
            if (r_s2_mode == MODE_KNEE) begin
                r_s3_acc <= QW'(w_num[PW-1:FRAC_BITS]);
                r_s3_div <= DIV_W'({w_rk, 1'b0});
            end else begin
                r_s3_acc <= QW'(r_s2_mag);
                r_s3_div <= DIV_W'(w_rh);
            end
            r_s3_side.mode <= r_s2_mode;
            r_s3_side.neg  <= r_s2_neg;
            r_s3_side.x    <= r_s2_x;
        end
    end

    assign w_stall3 = r_s3_valid & i_stall;
    assign w_stall2 = r_s2_valid & w_stall3;
    assign w_stall1 = r_s1_valid & w_stall2;

    assign o_stall = w_stall1;
    assign o_valid = r_s3_valid;
    assign o_acc   = r_s3_acc;
    assign o_div   = r_s3_div;
    assign o_side  = r_s3_side;

endmodule

[hdl/skc_div_stage.sv]
module skc_div_stage #(
    parameter int QW = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [QW-1:0]                 i_acc,
    input  logic [skc_pkg::DIV_W-1:0]     i_rem,
    input  logic [skc_pkg::DIV_W-1:0]     i_div,
    input  skc_pkg::t_side                i_side,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [QW-1:0]                 o_acc,
    output logic [skc_pkg::DIV_W-1:0]     o_rem,
    output logic [skc_pkg::DIV_W-1:0]     o_div,
    output skc_pkg::t_side                o_side
);
    import skc_pkg::*;

    // acc holds unconsumed dividend bits on top, quotient bits below
    logic [DIV_W:0]   w_try;
    logic [DIV_W-1:0] w_rem;
    logic [QW-1:0]    w_acc;

    always_comb begin
        w_rem = i_rem;
        w_acc = i_acc;
        w_try = '0;
        for (int k = 0; k < DIGITS_PER_STAGE; k++) begin
            w_try = {w_rem, w_acc[QW-1]};
            w_acc = {w_acc[QW-2:0], 1'b0};
            if (w_try >= {1'b0, i_div}) begin
                w_rem    = DIV_W'(w_try - {1'b0, i_div});
                w_acc[0] = 1'b1;
            end else begin
                w_rem = w_try[DIV_W-1:0];
            end
        end
    end

    logic             r_valid;
    logic [QW-1:0]    r_acc;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_div;
    t_side            r_side;

    assign o_stall = r_valid & i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_acc  <= w_acc;
            r_rem  <= w_rem;
            r_div  <= i_div;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_acc   = r_acc;
    assign o_rem   = r_rem;
    assign o_div   = r_div;
    assign o_side  = r_side;

endmodule

[hdl/skc_back.sv]
module skc_back #(
    parameter int FRAC_BITS = skc_pkg::FRAC_BITS_DEF,
    parameter int QW        = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  skc_pkg::t_cfg                       i_cfg,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [QW-1:0]                       i_quo,
    input  skc_pkg::t_side                      i_side,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [skc_pkg::LEVEL_W-1:0]  o_level_out,
    output logic                                o_above_full_scale,
    output logic                                o_saturated
);
    import skc_pkg::*;

    localparam int YW = QW + 2;
    localparam logic signed [YW-1:0] Y_MAX = YW'(32'sd32767);
    localparam logic signed [YW-1:0] Y_MIN = YW'(-32'sd32768);

    logic signed [YW-1:0] w_q, w_x, w_thr, w_mk, w_curve, w_y;
    logic                 w_hi, w_lo;

    assign w_q   = $signed(YW'(i_quo));
    assign w_x   = YW'(i_side.x);
    assign w_thr = YW'($signed(i_cfg.threshold_db)) <<< FRAC_BITS;
    assign w_mk  = $signed(YW'(i_cfg.makeup_db)) <<< FRAC_BITS;

    always_comb begin
        unique case (i_side.mode)
            MODE_PASS: w_curve = w_x;
            MODE_COMP: w_curve = i_side.neg ? (w_thr - w_q) : (w_thr + w_q);
            MODE_KNEE: w_curve = w_x - w_q;
            default:   w_curve = w_x;
        endcase
    end

    assign w_y  = w_curve + w_mk;
    assign w_hi = (w_y > Y_MAX);
    assign w_lo = (w_y < Y_MIN);

    logic                      r_valid;
    logic signed [LEVEL_W-1:0] r_level;
    logic                      r_above;
    logic                      r_sat;

    assign o_stall = r_valid & i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            priority if (w_hi) begin
                r_level <= Y_MAX[LEVEL_W-1:0];
            end else if (w_lo) begin
                r_level <= Y_MIN[LEVEL_W-1:0];
            end else begin
                r_level <= w_y[LEVEL_W-1:0];
            end
            r_above <= (w_y > 0);
            r_sat   <= w_hi | w_lo;
        end
    end

    assign o_valid            = r_valid;
    assign o_level_out        = r_level;
    assign o_above_full_scale = r_above;
    assign o_saturated        = r_sat;

endmodule

[hdl/soft_knee_compressor_gain.sv]
// Static gain curve of a soft-knee compressor, one level per beat.
// Input channel: i_in_valid / o_in_stall with i_level_in, a signed level in
//   dB with FRAC_BITS fraction bits. A beat moves when valid is high and
//   stall is low.
// Output channel: o_out_valid / i_out_stall with o_level_out (same format,
//   clamped to 16 bits), o_above_full_scale (unclamped level above 0 dB)
//   and o_saturated (clamp applied).
// Pipeline: three front stages (segment select, square, scale), one
//   divider stage per 8 quotient bits, one output stage. The restoring
//   divider sets the depth.
// Throughput: one beat per cycle, sustained, while the output is not stalled.
// Stall: each stage holds while its successor is full and stalled, so empty
//   stages still fill while the output waits; nothing is dropped or repeated.
// Reset (synchronous, active low): pipeline emptied, registers back to
//   threshold -22 dB, ratio 4:1, knee 3 dB, makeup 5 dB.
// Registers: APB at byte offsets 0 threshold, 4 ratio halves, 8 knee,
//   12 makeup. Write only while no beat is in flight.
module soft_knee_compressor_gain #(
    parameter int FRAC_BITS = skc_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [skc_pkg::LEVEL_W-1:0]  i_level_in,
    // output channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [skc_pkg::LEVEL_W-1:0]  o_level_out,
    output logic                                o_above_full_scale,
    output logic                                o_saturated,
    // register port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [3:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import skc_pkg::*;

    // divider geometry: dividend width rounded up to whole stages
    localparam int DW  = FRAC_BITS + 19;
    localparam int NDS = (DW + DIGITS_PER_STAGE - 1) / DIGITS_PER_STAGE;
    localparam int QW  = NDS * DIGITS_PER_STAGE;

    // ---------------- register file ----------------
    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{threshold_db: THR_RST, ratio_halves: RATIO_RST,
                       knee_db: KNEE_RST, makeup_db: MAKEUP_RST};
        end else if (w_wr) begin
            unique case (w_idx)
                REG_THRESHOLD: r_cfg.threshold_db <= $signed(pwdata[THR_W-1:0]);
                REG_RATIO:     r_cfg.ratio_halves <= pwdata[RATIO_W-1:0];
                REG_KNEE:      r_cfg.knee_db      <= pwdata[KNEE_W-1:0];
                REG_MAKEUP:    r_cfg.makeup_db    <= pwdata[MAKEUP_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_THRESHOLD: prdata = 32'($signed(r_cfg.threshold_db));
            REG_RATIO:     prdata = 32'(r_cfg.ratio_halves);
            REG_KNEE:      prdata = 32'(r_cfg.knee_db);
            REG_MAKEUP:    prdata = 32'(r_cfg.makeup_db);
        endcase
    end

    // ---------------- datapath ----------------
    // index 0 is the front end output, index NDS the last divider stage
    logic             w_dv    [NDS+1];
    logic             w_ds    [NDS+1];
    logic [QW-1:0]    w_dacc  [NDS+1];
    logic [DIV_W-1:0] w_drem  [NDS+1];
    logic [DIV_W-1:0] w_ddiv  [NDS+1];
    t_side            w_dside [NDS+1];

    // remainder starts at zero for every beat
    assign w_drem[0] = '0;

    skc_front #(
        .FRAC_BITS (FRAC_BITS),
        .QW        (QW)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_valid    (i_in_valid),
        .o_stall    (o_in_stall),
        .i_level_in (i_level_in),
        .o_valid    (w_dv[0]),
        .i_stall    (w_ds[0]),
        .o_acc      (w_dacc[0]),
        .o_div      (w_ddiv[0]),
        .o_side     (w_dside[0])
    );

    for (genvar g = 0; g < NDS; g++) begin : g_div
        skc_div_stage #(
            .QW (QW)
        ) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_dv[g]),
            .o_stall (w_ds[g]),
            .i_acc   (w_dacc[g]),
            .i_rem   (w_drem[g]),
            .i_div   (w_ddiv[g]),
            .i_side  (w_dside[g]),
            .o_valid (w_dv[g+1]),
            .i_stall (w_ds[g+1]),
            .o_acc   (w_dacc[g+1]),
            .o_rem   (w_drem[g+1]),
            .o_div   (w_ddiv[g+1]),
            .o_side  (w_dside[g+1])
        );
    end

    skc_back #(
        .FRAC_BITS (FRAC_BITS),
        .QW        (QW)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (r_cfg),
        .i_valid            (w_dv[NDS]),
        .o_stall            (w_ds[NDS]),
        .i_quo              (w_dacc[NDS]),
        .i_side             (w_dside[NDS]),
        .o_valid            (o_out_valid),
        .i_stall            (i_out_stall),
        .o_level_out        (o_level_out),
        .o_above_full_scale (o_above_full_scale),
        .o_saturated        (o_saturated)
    );

endmodule
